/* sv/dllm_pkg.sv */
package dllm_pkg;

   // Fixed field widths of the request and response items
   localparam int MODE_W   = 3;
   localparam int HANDLE_W = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Operation codes carried in the request mode field
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_BACK    = 3'd0,
      MODE_PUSH_FRONT   = 3'd1,
      MODE_POP_FRONT    = 3'd2,
      MODE_POP_BACK     = 3'd3,
      MODE_INSERT_AFTER = 3'd4,
      MODE_ERASE        = 3'd5
   } dllm_mode_type;

   // Completion codes carried in the response status field
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BADH  = 2'd3
   } dllm_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_LINK,
      S_FIX,
      S_DONE
   } dllm_state_type;

   // Response item as it leaves the sequencer
   typedef struct packed {
      dllm_status_type           status;
      logic [HANDLE_W-1:0]       node;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        count;
      logic [HANDLE_W-1:0]       head_node;
      logic [HANDLE_W-1:0]       tail_node;
      logic                      empty_res;
   } dllm_rsp_type;

endpackage

/* sv/dllm_if.sv */
// Request channel: one list operation per transfer
interface dllm_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [dllm_pkg::MODE_W-1:0]                mode;
   logic [dllm_pkg::HANDLE_W-1:0]              handle;
   logic                                       at_end;
   logic signed [dllm_pkg::VALUE_W-1:0]        value;

   modport source (output valid, output mode, output handle, output at_end, output value,
                   input ready);
   modport sink   (input valid, input mode, input handle, input at_end, input value,
                   output ready);
endinterface

// Response channel: one result per operation
interface dllm_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic [dllm_pkg::STATUS_W-1:0]              status;
   logic [dllm_pkg::HANDLE_W-1:0]              node;
   logic signed [dllm_pkg::VALUE_W-1:0]        removed_value;
   logic [dllm_pkg::COUNT_W-1:0]               count;
   logic [dllm_pkg::HANDLE_W-1:0]              head_node;
   logic [dllm_pkg::HANDLE_W-1:0]              tail_node;
   logic                                       empty_res;

   modport source (output valid, output status, output node, output removed_value,
                   output count, output head_node, output tail_node, output empty_res,
                   input ready);
   modport sink   (input valid, input status, input node, input removed_value,
                   input count, input head_node, input tail_node, input empty_res,
                   output ready);
endinterface

/* sv/dllm_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data
module dllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dllm_ctrl.sv */
// Operation sequencer: reads slot links, updates list registers, writes links back
module dllm_ctrl #(
   parameter  int NODES = 64,
   localparam int IDX_W = $clog2(NODES),
   localparam int PTR_W = $clog2(NODES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dllm_pkg::MODE_W-1:0]         req_mode,
   input  logic [dllm_pkg::HANDLE_W-1:0]       req_handle,
   input  logic                                req_at_end,
   input  logic signed [dllm_pkg::VALUE_W-1:0] req_value,

   output logic                                done_valid,
   input  logic                                done_ready,
   output dllm_pkg::dllm_rsp_type              done_data,

   output logic [IDX_W-1:0]                    val_rd_addr,
   input  logic [dllm_pkg::VALUE_W-1:0]        val_rd_data,
   output logic                                val_wr_en,
   output logic [IDX_W-1:0]                    val_wr_addr,
   output logic [dllm_pkg::VALUE_W-1:0]        val_wr_data,

   output logic [IDX_W-1:0]                    nxt_rd_addr,
   input  logic [PTR_W-1:0]                    nxt_rd_data,
   output logic                                nxt_wr_en,
   output logic [IDX_W-1:0]                    nxt_wr_addr,
   output logic [PTR_W-1:0]                    nxt_wr_data,

   output logic [IDX_W-1:0]                    prv_rd_addr,
   input  logic [PTR_W-1:0]                    prv_rd_data,
   output logic                                prv_wr_en,
   output logic [IDX_W-1:0]                    prv_wr_addr,
   output logic [PTR_W-1:0]                    prv_wr_data,

   output logic [IDX_W-1:0]                    use_rd_addr,
   input  logic                                use_rd_data,
   output logic                                use_wr_en,
   output logic [IDX_W-1:0]                    use_wr_addr,
   output logic                                use_wr_data
);

   localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);
   localparam int CMP_W = (PTR_W > dllm_pkg::HANDLE_W) ? PTR_W : dllm_pkg::HANDLE_W;
   localparam int CNT_W = (PTR_W > dllm_pkg::COUNT_W) ? PTR_W : dllm_pkg::COUNT_W;

   dllm_pkg::dllm_state_type             state_ff, state_in;
   dllm_pkg::dllm_mode_type              mode_ff, mode_in;
   logic [dllm_pkg::HANDLE_W-1:0]        handle_ff, handle_in;
   logic                                 at_end_ff, at_end_in;
   logic signed [dllm_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [PTR_W-1:0]                     slot_ff, slot_in;
   logic [PTR_W-1:0]                     aux_ff, aux_in;
   logic [PTR_W-1:0]                     nb_ff, nb_in;
   dllm_pkg::dllm_status_type            status_ff, status_in;
   logic [dllm_pkg::HANDLE_W-1:0]        node_ff, node_in;
   logic signed [dllm_pkg::VALUE_W-1:0]  removed_ff, removed_in;
   logic [PTR_W-1:0]                     free_head_ff, free_head_in;
   logic [PTR_W-1:0]                     fresh_ff, fresh_in;
   logic [PTR_W-1:0]                     first_ff, first_in;
   logic [PTR_W-1:0]                     last_ff, last_in;
   logic [PTR_W-1:0]                     count_ff, count_in;

   dllm_pkg::dllm_mode_type              req_mode_e;
   logic                                 req_is_alloc;
   logic [CMP_W-1:0]                     req_h_cmp;
   logic [PTR_W-1:0]                     req_sel_ptr;
   logic [CMP_W-1:0]                     h_cmp;
   logic [PTR_W-1:0]                     h_ptr;
   logic                                 h_ok;
   logic                                 have_free;
   logic                                 have_fresh;
   logic [PTR_W-1:0]                     alloc_ptr;
   logic [PTR_W-1:0]                     ins_pos;
   logic [PTR_W-1:0]                     drop_ptr;
   logic [CMP_W-1:0]                     alloc_cmp;
   logic [CMP_W-1:0]                     drop_cmp;
   logic [CMP_W-1:0]                     first_cmp;
   logic [CMP_W-1:0]                     last_cmp;
   logic [CNT_W-1:0]                     count_ext;

   // Decode the incoming request for the read addresses issued at transfer
   assign req_mode_e   = dllm_pkg::dllm_mode_type'(req_mode);
   assign req_is_alloc = (req_mode_e == dllm_pkg::MODE_PUSH_BACK) ||
                         (req_mode_e == dllm_pkg::MODE_PUSH_FRONT) ||
                         (req_mode_e == dllm_pkg::MODE_INSERT_AFTER);
   assign req_h_cmp    = CMP_W'(req_handle);
   assign req_sel_ptr  = (req_mode_e == dllm_pkg::MODE_POP_FRONT) ? first_ff :
                         (req_mode_e == dllm_pkg::MODE_POP_BACK)  ? last_ff  :
                         req_h_cmp[PTR_W-1:0];

   // Handle check: a slot at or above the fill mark was never allocated
   assign h_cmp = CMP_W'(handle_ff);
   assign h_ptr = h_cmp[PTR_W-1:0];
   assign h_ok  = (h_cmp < CMP_W'(fresh_ff)) && use_rd_data;

   // Slot choices for the held operation
   assign have_free  = (free_head_ff != NIL);
   assign have_fresh = (fresh_ff != NIL);
   assign alloc_ptr  = have_free ? free_head_ff : fresh_ff;
   assign ins_pos    = (mode_ff == dllm_pkg::MODE_INSERT_AFTER && !at_end_ff) ? h_ptr : last_ff;
   assign drop_ptr   = (mode_ff == dllm_pkg::MODE_POP_FRONT) ? first_ff :
                       (mode_ff == dllm_pkg::MODE_POP_BACK)  ? last_ff  : h_ptr;
   assign alloc_cmp  = CMP_W'(alloc_ptr);
   assign drop_cmp   = CMP_W'(drop_ptr);

   // State register and held operands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dllm_pkg::S_IDLE;
         free_head_ff <= NIL;
         fresh_ff     <= '0;
         first_ff     <= NIL;
         last_ff      <= NIL;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      handle_ff  <= handle_in;
      at_end_ff  <= at_end_in;
      value_ff   <= value_in;
      slot_ff    <= slot_in;
      aux_ff     <= aux_in;
      nb_ff      <= nb_in;
      status_ff  <= status_in;
      node_ff    <= node_in;
      removed_ff <= removed_in;
   end

   // Next state, list updates and memory accesses
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      handle_in    = handle_ff;
      at_end_in    = at_end_ff;
      value_in     = value_ff;
      slot_in      = slot_ff;
      aux_in       = aux_ff;
      nb_in        = nb_ff;
      status_in    = status_ff;
      node_in      = node_ff;
      removed_in   = removed_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      count_in     = count_ff;

      req_ready  = 1'b0;
      done_valid = 1'b0;

      val_rd_addr = req_sel_ptr[IDX_W-1:0];
      prv_rd_addr = req_sel_ptr[IDX_W-1:0];
      use_rd_addr = req_h_cmp[IDX_W-1:0];
      nxt_rd_addr = req_is_alloc ? free_head_ff[IDX_W-1:0] : req_sel_ptr[IDX_W-1:0];

      val_wr_en   = 1'b0;
      val_wr_addr = alloc_ptr[IDX_W-1:0];
      val_wr_data = value_ff;
      nxt_wr_en   = 1'b0;
      nxt_wr_addr = slot_ff[IDX_W-1:0];
      nxt_wr_data = NIL;
      prv_wr_en   = 1'b0;
      prv_wr_addr = slot_ff[IDX_W-1:0];
      prv_wr_data = NIL;
      use_wr_en   = 1'b0;
      use_wr_addr = alloc_ptr[IDX_W-1:0];
      use_wr_data = 1'b0;

      case (state_ff)
         dllm_pkg::S_IDLE: begin
            // Take a request; the slot reads go out with the transfer
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in    = req_mode_e;
               handle_in  = req_handle;
               at_end_in  = req_at_end;
               value_in   = req_value;
               status_in  = dllm_pkg::ST_OK;
               node_in    = '0;
               removed_in = '0;
               state_in   = dllm_pkg::S_DECIDE;
            end
         end

         dllm_pkg::S_DECIDE: begin
            state_in = dllm_pkg::S_DONE;
            case (mode_ff)
               dllm_pkg::MODE_PUSH_BACK,
               dllm_pkg::MODE_PUSH_FRONT,
               dllm_pkg::MODE_INSERT_AFTER: begin
                  if (mode_ff == dllm_pkg::MODE_INSERT_AFTER && !at_end_ff && !h_ok) begin
                     status_in = dllm_pkg::ST_BADH;
                  end else if (!have_free && !have_fresh) begin
                     status_in = dllm_pkg::ST_FULL;
                  end else begin
                     // Allocate: free chain first, then a fresh slot
                     if (have_free) begin
                        free_head_in = nxt_rd_data;
                     end else begin
                        fresh_in = fresh_ff + PTR_W'(1);
                     end
                     slot_in     = alloc_ptr;
                     node_in     = alloc_cmp[dllm_pkg::HANDLE_W-1:0];
                     val_wr_en   = 1'b1;
                     use_wr_en   = 1'b1;
                     use_wr_data = 1'b1;
                     nxt_wr_addr = alloc_ptr[IDX_W-1:0];
                     prv_wr_addr = alloc_ptr[IDX_W-1:0];
                     prv_wr_en   = 1'b1;
                     if (mode_ff == dllm_pkg::MODE_PUSH_FRONT) begin
                        nxt_wr_en = 1'b1;
                        count_in  = count_ff + PTR_W'(1);
                        first_in  = alloc_ptr;
                        if (first_ff == NIL) begin
                           last_in = alloc_ptr;
                        end else begin
                           // Hook the old head behind the new slot
                           nxt_wr_data = first_ff;
                           aux_in      = first_ff;
                           state_in    = dllm_pkg::S_FIX;
                        end
                     end else if (ins_pos == NIL) begin
                        nxt_wr_en = 1'b1;
                        count_in  = count_ff + PTR_W'(1);
                        first_in  = alloc_ptr;
                        last_in   = alloc_ptr;
                     end else begin
                        // Fetch the successor of the insert position
                        prv_wr_data = ins_pos;
                        nxt_rd_addr = ins_pos[IDX_W-1:0];
                        aux_in      = ins_pos;
                        state_in    = dllm_pkg::S_LINK;
                     end
                  end
               end

               dllm_pkg::MODE_POP_FRONT,
               dllm_pkg::MODE_POP_BACK,
               dllm_pkg::MODE_ERASE: begin
                  if (mode_ff == dllm_pkg::MODE_ERASE && at_end_ff) begin
                     status_in = dllm_pkg::ST_OK;
                  end else if (mode_ff == dllm_pkg::MODE_ERASE && !h_ok) begin
                     status_in = dllm_pkg::ST_BADH;
                  end else if (drop_ptr == NIL) begin
                     status_in = dllm_pkg::ST_EMPTY;
                  end else begin
                     // Unlink the slot and push it on the free chain
                     slot_in      = drop_ptr;
                     node_in      = drop_cmp[dllm_pkg::HANDLE_W-1:0];
                     removed_in   = val_rd_data;
                     aux_in       = prv_rd_data;
                     nb_in        = nxt_rd_data;
                     use_wr_en    = 1'b1;
                     use_wr_addr  = drop_ptr[IDX_W-1:0];
                     use_wr_data  = 1'b0;
                     nxt_wr_en    = 1'b1;
                     nxt_wr_addr  = drop_ptr[IDX_W-1:0];
                     nxt_wr_data  = free_head_ff;
                     prv_wr_en    = 1'b1;
                     prv_wr_addr  = drop_ptr[IDX_W-1:0];
                     free_head_in = drop_ptr;
                     count_in     = count_ff - PTR_W'(1);
                     if (prv_rd_data == NIL) begin
                        first_in = nxt_rd_data;
                     end
                     if (nxt_rd_data == NIL) begin
                        last_in = prv_rd_data;
                     end
                     state_in = dllm_pkg::S_FIX;
                  end
               end

               default: begin
                  status_in = dllm_pkg::ST_OK;
               end
            endcase
         end

         dllm_pkg::S_LINK: begin
            // Splice the new slot in front of the fetched successor
            nb_in       = nxt_rd_data;
            nxt_wr_en   = 1'b1;
            nxt_wr_data = nxt_rd_data;
            count_in    = count_ff + PTR_W'(1);
            if (nxt_rd_data != NIL) begin
               prv_wr_en   = 1'b1;
               prv_wr_addr = nxt_rd_data[IDX_W-1:0];
               prv_wr_data = slot_ff;
            end else begin
               last_in = slot_ff;
            end
            state_in = dllm_pkg::S_FIX;
         end

         dllm_pkg::S_FIX: begin
            // Finish the neighbor link updates
            if (mode_ff == dllm_pkg::MODE_PUSH_FRONT) begin
               prv_wr_en   = 1'b1;
               prv_wr_addr = aux_ff[IDX_W-1:0];
               prv_wr_data = slot_ff;
            end else if (mode_ff == dllm_pkg::MODE_POP_FRONT ||
                         mode_ff == dllm_pkg::MODE_POP_BACK ||
                         mode_ff == dllm_pkg::MODE_ERASE) begin
               nxt_wr_en   = (aux_ff != NIL);
               nxt_wr_addr = aux_ff[IDX_W-1:0];
               nxt_wr_data = nb_ff;
               prv_wr_en   = (nb_ff != NIL);
               prv_wr_addr = nb_ff[IDX_W-1:0];
               prv_wr_data = aux_ff;
            end else begin
               nxt_wr_en   = 1'b1;
               nxt_wr_addr = aux_ff[IDX_W-1:0];
               nxt_wr_data = slot_ff;
            end
            state_in = dllm_pkg::S_DONE;
         end

         dllm_pkg::S_DONE: begin
            // Hold the result until the output stage takes it
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = dllm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = dllm_pkg::S_IDLE;
         end
      endcase
   end

   // Build the result from the updated list registers
   assign first_cmp = CMP_W'(first_ff);
   assign last_cmp  = CMP_W'(last_ff);
   assign count_ext = CNT_W'(count_ff);

   assign done_data.status        = status_ff;
   assign done_data.node          = node_ff;
   assign done_data.removed_value = removed_ff;
   assign done_data.count         = count_ext[dllm_pkg::COUNT_W-1:0];
   assign done_data.head_node     = (first_ff != NIL) ? first_cmp[dllm_pkg::HANDLE_W-1:0] : '0;
   assign done_data.tail_node     = (last_ff != NIL) ? last_cmp[dllm_pkg::HANDLE_W-1:0] : '0;
   assign done_data.empty_res     = (count_ff == '0);

   // List bookkeeping stays consistent between operations
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= NIL) && (fresh_ff <= NIL))
      else $error("element count or fill mark beyond pool size");

   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dllm_pkg::S_IDLE) |-> ((first_ff == NIL) == (count_ff == '0)))
      else $error("head pointer disagrees with element count");

   a_head_vs_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dllm_pkg::S_IDLE) |-> ((first_ff == NIL) == (last_ff == NIL)))
      else $error("head and tail pointers disagree on empty list");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dllm_pkg::S_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("element count changed without an operation");

endmodule

/* sv/doubly_linked_list_manager_top.sv */
// Channel   Dir  Transfer              Payload
// req_ch    in   valid & ready         mode, handle, at_end, value
// rsp_ch    out  valid & ready         status, node, removed_value, count,
//                                      head_node, tail_node, empty_res
//
// One operation at a time. A failed op, a no-op code or a push into an empty list goes
// from decide to done; pops, erase and push front pass through the fix state, push back
// and insert after through link and then fix. The done state holds until the output
// register takes the result. The sequence is set by the registered read of the link memories and
// by their single write port (two links per memory). Reset is synchronous; it clears the list registers, the fill
// mark and the sequencer. A stalled response waits in the output register while the
// next request is worked.
module doubly_linked_list_manager_top #(
   parameter int NODES = 64
) (
   input  logic       clock,
   input  logic       reset,
   dllm_req_if.sink   req_ch,
   dllm_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(NODES);
   localparam int PTR_W = $clog2(NODES + 1);

   logic                          done_valid;
   logic                          done_ready;
   dllm_pkg::dllm_rsp_type        done_data;

   logic [IDX_W-1:0]              val_rd_addr, val_wr_addr;
   logic [dllm_pkg::VALUE_W-1:0]  val_rd_data, val_wr_data;
   logic                          val_wr_en;
   logic [IDX_W-1:0]              nxt_rd_addr, nxt_wr_addr;
   logic [PTR_W-1:0]              nxt_rd_data, nxt_wr_data;
   logic                          nxt_wr_en;
   logic [IDX_W-1:0]              prv_rd_addr, prv_wr_addr;
   logic [PTR_W-1:0]              prv_rd_data, prv_wr_data;
   logic                          prv_wr_en;
   logic [IDX_W-1:0]              use_rd_addr, use_wr_addr;
   logic                          use_rd_data, use_wr_data;
   logic                          use_wr_en;

   logic                          rsp_valid_ff, rsp_valid_in;
   dllm_pkg::dllm_rsp_type        rsp_data_ff, rsp_data_in;

   // Slot memories: value, forward link, backward link, in-use flag
   dllm_ram #(.WIDTH(dllm_pkg::VALUE_W), .DEPTH(NODES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   dllm_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_wr_en),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_addr (nxt_rd_addr),
      .rd_data (nxt_rd_data)
   );

   dllm_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_wr_en),
      .wr_addr (prv_wr_addr),
      .wr_data (prv_wr_data),
      .rd_addr (prv_rd_addr),
      .rd_data (prv_rd_data)
   );

   dllm_ram #(.WIDTH(1), .DEPTH(NODES)) u_use_ram (
      .clock   (clock),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data),
      .rd_addr (use_rd_addr),
      .rd_data (use_rd_data)
   );

   dllm_ctrl #(.NODES(NODES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_mode    (req_ch.mode),
      .req_handle  (req_ch.handle),
      .req_at_end  (req_ch.at_end),
      .req_value   (req_ch.value),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .val_rd_addr (val_rd_addr),
      .val_rd_data (val_rd_data),
      .val_wr_en   (val_wr_en),
      .val_wr_addr (val_wr_addr),
      .val_wr_data (val_wr_data),
      .nxt_rd_addr (nxt_rd_addr),
      .nxt_rd_data (nxt_rd_data),
      .nxt_wr_en   (nxt_wr_en),
      .nxt_wr_addr (nxt_wr_addr),
      .nxt_wr_data (nxt_wr_data),
      .prv_rd_addr (prv_rd_addr),
      .prv_rd_data (prv_rd_data),
      .prv_wr_en   (prv_wr_en),
      .prv_wr_addr (prv_wr_addr),
      .prv_wr_data (prv_wr_data),
      .use_rd_addr (use_rd_addr),
      .use_rd_data (use_rd_data),
      .use_wr_en   (use_wr_en),
      .use_wr_addr (use_wr_addr),
      .use_wr_data (use_wr_data)
   );

   // Output register: load when empty or when the current result transfers
   assign done_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_ready) begin
         rsp_valid_in = done_valid;
         if (done_valid) begin
            rsp_data_in = done_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Drive the response channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.node          = rsp_data_ff.node;
   assign rsp_ch.removed_value = rsp_data_ff.removed_value;
   assign rsp_ch.count         = rsp_data_ff.count;
   assign rsp_ch.head_node     = rsp_data_ff.head_node;
   assign rsp_ch.tail_node     = rsp_data_ff.tail_node;
   assign rsp_ch.empty_res     = rsp_data_ff.empty_res;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int          POOL_SLOTS        = 64;
   localparam bit [6:0]    NO_SLOT           = 7'd64;
   localparam logic [2:0]  MODE_UNUSED6      = 3'd6;
   localparam logic [2:0]  MODE_UNUSED7      = 3'd7;
   localparam int          RANDOM_OPS        = 1300;
   localparam int          LONG_HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES      = 20;
   localparam int          LIMIT_CYCLES      = 400000;
   localparam int          REPORT_LIMIT      = 10;

   // One list operation plus an optional hand-written expectation
   typedef struct {
      logic [dllm_pkg::MODE_W-1:0]         mode;
      logic [dllm_pkg::HANDLE_W-1:0]       handle;
      logic                                at_end;
      logic signed [dllm_pkg::VALUE_W-1:0] value;
      bit                                  pinned;
      dllm_pkg::dllm_rsp_type              pinned_rsp;
   } list_op_type;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_kind_type;

   logic clock;
   logic reset;

   dllm_req_if req_if ();
   dllm_rsp_if rsp_if ();

   doubly_linked_list_manager_top #(
      .NODES (POOL_SLOTS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow copy of the slot pool and list registers
   logic signed [dllm_pkg::VALUE_W-1:0] pool_value [POOL_SLOTS];
   bit [6:0]                  pool_next  [POOL_SLOTS];
   bit [6:0]                  pool_prev  [POOL_SLOTS];
   bit [POOL_SLOTS-1:0]       pool_used  = '0;
   bit [6:0]                  free_top   = NO_SLOT;
   bit [6:0]                  fresh_mark = '0;
   bit [6:0]                  head_slot  = NO_SLOT;
   bit [6:0]                  tail_slot  = NO_SLOT;
   bit [6:0]                  n_elems    = '0;

   dllm_pkg::dllm_rsp_type pending_rsp_q [$];
   list_op_type            directed_q [$];
   list_op_type            cur_op;

   int  fail_count   = 0;
   int  cycle_count  = 0;
   int  ops_accepted = 0;
   int  rsp_seen     = 0;
   int  status_hits [4];
   int  peak_count   = 0;
   int  burst_left   = 0;
   bit  gaps_on      = 1'b1;
   bit  hold_off_req = 1'b0;
   int  hold_left    = 0;
   int  rx_style     = 0;
   int  rx_window    = 0;
   int  rx_phase     = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow list and return the result it gives
   function automatic dllm_pkg::dllm_rsp_type predict_list_op(list_op_type op);
      dllm_pkg::dllm_rsp_type r;
      bit [6:0]     h;
      bit [6:0]     s;
      bit [6:0]     p;
      bit [6:0]     n;
      bit           h_ok;
      r        = '0;
      r.status = dllm_pkg::ST_OK;
      h        = {1'b0, op.handle};
      h_ok     = pool_used[op.handle];
      case (op.mode)
         dllm_pkg::MODE_PUSH_BACK, dllm_pkg::MODE_PUSH_FRONT,
         dllm_pkg::MODE_INSERT_AFTER: begin
            if (op.mode == dllm_pkg::MODE_INSERT_AFTER && !op.at_end && !h_ok) begin
               r.status = dllm_pkg::ST_BADH;
            end else begin
               // take from the free chain first, then a fresh slot
               if (free_top != NO_SLOT) begin
                  s        = free_top;
                  free_top = pool_next[s[5:0]];
               end else if (fresh_mark != NO_SLOT) begin
                  s          = fresh_mark;
                  fresh_mark = fresh_mark + 7'd1;
               end else begin
                  s = NO_SLOT;
               end
               if (s == NO_SLOT) begin
                  r.status = dllm_pkg::ST_FULL;
               end else begin
                  pool_value[s[5:0]] = op.value;
                  pool_next[s[5:0]]  = NO_SLOT;
                  pool_prev[s[5:0]]  = NO_SLOT;
                  pool_used[s[5:0]]  = 1'b1;
                  if (op.mode == dllm_pkg::MODE_PUSH_FRONT) begin
                     if (head_slot == NO_SLOT) begin
                        head_slot = s;
                        tail_slot = s;
                     end else begin
                        pool_next[s[5:0]]         = head_slot;
                        pool_prev[head_slot[5:0]] = s;
                        head_slot                 = s;
                     end
                  end else begin
                     p = (op.mode == dllm_pkg::MODE_INSERT_AFTER && !op.at_end) ?
                         h : tail_slot;
                     if (p == NO_SLOT) begin
                        head_slot = s;
                        tail_slot = s;
                     end else begin
                        n                  = pool_next[p[5:0]];
                        pool_next[s[5:0]]  = n;
                        pool_prev[s[5:0]]  = p;
                        if (n != NO_SLOT) pool_prev[n[5:0]] = s;
                        else tail_slot = s;
                        pool_next[p[5:0]]  = s;
                     end
                  end
                  n_elems = n_elems + 7'd1;
                  r.node  = s[5:0];
               end
            end
         end
         dllm_pkg::MODE_POP_FRONT, dllm_pkg::MODE_POP_BACK, dllm_pkg::MODE_ERASE: begin
            if (op.mode == dllm_pkg::MODE_ERASE && op.at_end) begin
               // erase with no position: leave the list alone
            end else if (op.mode == dllm_pkg::MODE_ERASE && !h_ok) begin
               r.status = dllm_pkg::ST_BADH;
            end else begin
               if (op.mode == dllm_pkg::MODE_ERASE) s = h;
               else if (op.mode == dllm_pkg::MODE_POP_FRONT) s = head_slot;
               else s = tail_slot;
               if (s == NO_SLOT) begin
                  r.status = dllm_pkg::ST_EMPTY;
               end else begin
                  // unlink and push onto the free chain
                  r.node          = s[5:0];
                  r.removed_value = pool_value[s[5:0]];
                  p = pool_prev[s[5:0]];
                  n = pool_next[s[5:0]];
                  if (p != NO_SLOT) pool_next[p[5:0]] = n;
                  else head_slot = n;
                  if (n != NO_SLOT) pool_prev[n[5:0]] = p;
                  else tail_slot = p;
                  pool_used[s[5:0]] = 1'b0;
                  pool_next[s[5:0]] = free_top;
                  pool_prev[s[5:0]] = NO_SLOT;
                  free_top          = s;
                  n_elems           = n_elems - 7'd1;
               end
            end
         end
         default: begin
         end
      endcase
      r.count     = n_elems;
      r.head_node = (head_slot != NO_SLOT) ? head_slot[5:0] : '0;
      r.tail_node = (tail_slot != NO_SLOT) ? tail_slot[5:0] : '0;
      r.empty_res = (n_elems == 0);
      return r;
   endfunction

   function automatic dllm_pkg::dllm_rsp_type rsp_of(dllm_pkg::dllm_status_type st, int node,
                                                     int rem, int cnt, int hd, int tl,
                                                     bit emp);
      dllm_pkg::dllm_rsp_type r;
      r.status        = st;
      r.node          = node[dllm_pkg::HANDLE_W-1:0];
      r.removed_value = rem;
      r.count         = cnt[dllm_pkg::COUNT_W-1:0];
      r.head_node     = hd[dllm_pkg::HANDLE_W-1:0];
      r.tail_node     = tl[dllm_pkg::HANDLE_W-1:0];
      r.empty_res     = emp;
      return r;
   endfunction

   function automatic void add_row(logic [dllm_pkg::MODE_W-1:0] mode, int h, bit e,
                                   logic signed [dllm_pkg::VALUE_W-1:0] v, bit pinned,
                                   dllm_pkg::dllm_rsp_type x);
      list_op_type op;
      op.mode       = mode;
      op.handle     = h[dllm_pkg::HANDLE_W-1:0];
      op.at_end     = e;
      op.value      = v;
      op.pinned     = pinned;
      op.pinned_rsp = x;
      directed_q.insert(directed_q.size(), op);
   endfunction

   function automatic string fmt_rsp(dllm_pkg::dllm_rsp_type r);
      return $sformatf("st=%0d node=%0d rem=%0d cnt=%0d head=%0d tail=%0d empty=%0d",
                       r.status, r.node, r.removed_value, r.count, r.head_node,
                       r.tail_node, r.empty_res);
   endfunction

   // Mostly an in-use slot, sometimes any slot number
   function automatic logic [dllm_pkg::HANDLE_W-1:0] pick_handle();
      int start;
      int idx;
      start = $urandom_range(0, POOL_SLOTS - 1);
      if (n_elems != 0 && $urandom_range(0, 9) != 0) begin
         for (int i = 0; i < POOL_SLOTS; i++) begin
            idx = (start + i) % POOL_SLOTS;
            if (pool_used[idx]) return idx[dllm_pkg::HANDLE_W-1:0];
         end
      end
      return start[dllm_pkg::HANDLE_W-1:0];
   endfunction

   function automatic logic signed [dllm_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic list_op_type make_op(phase_kind_type k);
      list_op_type op;
      int          r;
      int          pick;
      op.pinned     = 1'b0;
      op.pinned_rsp = '0;
      op.value      = pick_value();
      op.handle     = pick_handle();
      op.at_end     = 1'b0;
      r             = $urandom_range(0, 99);
      case (k)
         PH_GROW: begin
            if (r < 40) op.mode = dllm_pkg::MODE_PUSH_BACK;
            else if (r < 70) op.mode = dllm_pkg::MODE_PUSH_FRONT;
            else begin
               op.mode   = dllm_pkg::MODE_INSERT_AFTER;
               op.at_end = ($urandom_range(0, 9) == 0);
            end
         end
         PH_SHRINK: begin
            if (r < 35) op.mode = dllm_pkg::MODE_POP_FRONT;
            else if (r < 70) op.mode = dllm_pkg::MODE_POP_BACK;
            else begin
               op.mode   = dllm_pkg::MODE_ERASE;
               op.at_end = ($urandom_range(0, 19) == 0);
            end
         end
         PH_MIXED: begin
            pick      = $urandom_range(0, 5);
            op.mode   = pick[dllm_pkg::MODE_W-1:0];
            op.at_end = ($urandom_range(0, 7) == 0);
         end
         default: begin
            pick      = $urandom_range(0, 7);
            op.mode   = pick[dllm_pkg::MODE_W-1:0];
            pick      = $urandom_range(0, POOL_SLOTS - 1);
            op.handle = pick[dllm_pkg::HANDLE_W-1:0];
            op.at_end = ($urandom_range(0, 1) == 1);
         end
      endcase
      return op;
   endfunction

   // Offer one operation and hold it until the transfer
   task automatic send_op(list_op_type op);
      @(negedge clock);
      cur_op         = op;
      req_if.valid  <= 1'b1;
      req_if.mode   <= op.mode;
      req_if.handle <= op.handle;
      req_if.at_end <= op.at_end;
      req_if.value  <= op.value;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
   endtask

   // Bursts of back-to-back operations separated by random gaps when gaps are enabled
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 30);
         if (gaps_on) begin
            gap = $urandom_range(1, 8);
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Receiver: long hold on request, otherwise a rotating stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_off_req) begin
         hold_off_req  = 1'b0;
         hold_left     = LONG_HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_window == 0) begin
            rx_style  = $urandom_range(0, 3);
            rx_window = $urandom_range(20, 80);
         end
         rx_window = rx_window - 1;
         rx_phase  = rx_phase + 1;
         case (rx_style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_if.ready <= (rx_phase % 4 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // Check results in order, then predict for each accepted operation
   always @(posedge clock) begin : monitor
      dllm_pkg::dllm_rsp_type got;
      dllm_pkg::dllm_rsp_type want;
      bit                     bad;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status        = dllm_pkg::dllm_status_type'(rsp_if.status);
            got.node          = rsp_if.node;
            got.removed_value = rsp_if.removed_value;
            got.count         = rsp_if.count;
            got.head_node     = rsp_if.head_node;
            got.tail_node     = rsp_if.tail_node;
            got.empty_res     = rsp_if.empty_res;
            rsp_seen++;
            if (pending_rsp_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("[%0t] result with none pending: %s", $realtime, fmt_rsp(got));
               fail_count++;
            end else begin
               want = pending_rsp_q[0];
               pending_rsp_q.delete(0);
               bad  = (got.status !== want.status) || (got.node !== want.node) ||
                      (got.removed_value !== want.removed_value) ||
                      (got.count !== want.count) || (got.head_node !== want.head_node) ||
                      (got.tail_node !== want.tail_node) || (got.empty_res !== want.empty_res);
               if (bad) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("[%0t] result %0d mismatch", $realtime, rsp_seen);
                     $display("   expected %s", fmt_rsp(want));
                     $display("   actual   %s", fmt_rsp(got));
                  end
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_list_op(cur_op);
            if (cur_op.pinned) want = cur_op.pinned_rsp;
            pending_rsp_q.insert(pending_rsp_q.size(), want);
            ops_accepted++;
            status_hits[want.status]++;
            if (want.count > peak_count) peak_count = want.count;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_rsp_q.size());
         $display("FAIL doubly_linked_list_manager_top");
         $finish;
      end
   end

   initial begin : stimulus
      list_op_type    op;
      phase_kind_type kind;
      int             rand_work;
      int             phase_idx;
      int             len;
      int             r;
      rand_work     = 0;
      phase_idx     = 0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.mode   = '0;
      req_if.handle = '0;
      req_if.at_end = 1'b0;
      req_if.value  = '0;
      for (int i = 0; i < 4; i++) status_hits[i] = 0;

      // Hold reset, then release it on a falling clock edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty-list errors, bad handles, unused codes, extremes, relinking
      add_row(dllm_pkg::MODE_POP_FRONT, 0, 1'b0, 0, 1'b1,
              rsp_of(dllm_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 1'b1));
      add_row(dllm_pkg::MODE_POP_BACK, 63, 1'b1, -1, 1'b1,
              rsp_of(dllm_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 1'b1));
      add_row(dllm_pkg::MODE_ERASE, 63, 1'b1, 0, 1'b1,
              rsp_of(dllm_pkg::ST_OK, 0, 0, 0, 0, 0, 1'b1));
      add_row(dllm_pkg::MODE_ERASE, 5, 1'b0, 0, 1'b1,
              rsp_of(dllm_pkg::ST_BADH, 0, 0, 0, 0, 0, 1'b1));
      add_row(dllm_pkg::MODE_INSERT_AFTER, 0, 1'b0, 7, 1'b1,
              rsp_of(dllm_pkg::ST_BADH, 0, 0, 0, 0, 0, 1'b1));
      add_row(MODE_UNUSED6, 63, 1'b1, -1, 1'b1,
              rsp_of(dllm_pkg::ST_OK, 0, 0, 0, 0, 0, 1'b1));
      add_row(MODE_UNUSED7, 42, 1'b0, 32'sh5555_5555, 1'b1,
              rsp_of(dllm_pkg::ST_OK, 0, 0, 0, 0, 0, 1'b1));
      add_row(dllm_pkg::MODE_PUSH_BACK, 0, 1'b0, 32'sh8000_0000, 1'b1,
              rsp_of(dllm_pkg::ST_OK, 0, 0, 1, 0, 0, 1'b0));
      add_row(dllm_pkg::MODE_PUSH_FRONT, 0, 1'b0, 32'sh7fff_ffff, 1'b1,
              rsp_of(dllm_pkg::ST_OK, 1, 0, 2, 1, 0, 1'b0));
      add_row(dllm_pkg::MODE_INSERT_AFTER, 21, 1'b1, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_INSERT_AFTER, 1, 1'b0, -1, 1'b0, '0);
      add_row(dllm_pkg::MODE_INSERT_AFTER, 2, 1'b0, 1, 1'b0, '0);
      add_row(dllm_pkg::MODE_ERASE, 3, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_FRONT, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_BACK, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_PUSH_BACK, 0, 1'b0, 32'sh1234_5678, 1'b0, '0);
      add_row(dllm_pkg::MODE_ERASE, 63, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_INSERT_AFTER, 63, 1'b0, 9, 1'b0, '0);
      add_row(dllm_pkg::MODE_ERASE, 0, 1'b1, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_PUSH_FRONT, 0, 1'b0, -2, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_BACK, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_FRONT, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_FRONT, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_BACK, 0, 1'b0, 0, 1'b0, '0);
      add_row(dllm_pkg::MODE_POP_FRONT, 0, 1'b0, 0, 1'b1,
              rsp_of(dllm_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 1'b1));
      foreach (directed_q[i]) begin
         send_op(directed_q[i]);
         pace_sender();
      end

      // Random phases: growth to full, drain to empty, mixed traffic, raw noise
      while (rand_work < RANDOM_OPS) begin
         r = $urandom_range(0, 9);
         if (r < 3) kind = PH_GROW;
         else if (r < 6) kind = PH_SHRINK;
         else if (r < 9) kind = PH_MIXED;
         else kind = PH_NOISE;
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase_idx == 2) begin
            // hold the receiver off while operations keep coming
            gaps_on      = 1'b0;
            hold_off_req = 1'b1;
         end
         if (phase_idx % 7 == 5) wait_all_results();
         len = $urandom_range(10, 80);
         for (int j = 0; j < len && rand_work < RANDOM_OPS; j++) begin
            op = make_op(kind);
            send_op(op);
            rand_work++;
            pace_sender();
         end
         phase_idx++;
      end

      // Let the last results drain
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $display("%0d expected results never arrived", pending_rsp_q.size());
         fail_count++;
      end

      $display("%0d operations in %0d phases, peak list length %0d, %0d cycles",
               ops_accepted, phase_idx, peak_count, cycle_count);
      $display("outcomes: ok %0d, empty %0d, full %0d, bad handle %0d; failures %0d",
               status_hits[dllm_pkg::ST_OK], status_hits[dllm_pkg::ST_EMPTY],
               status_hits[dllm_pkg::ST_FULL], status_hits[dllm_pkg::ST_BADH], fail_count);
      if (fail_count == 0) begin
         $display("PASS doubly_linked_list_manager_top");
      end else begin
         $display("FAIL doubly_linked_list_manager_top");
      end
      $finish;
   end

endmodule
